[design/rxps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxps_pkg
// Shared types and constants of the rolling XOR packet scrambler.
// ----------------------------------------------------------------------------
package rxps_pkg;

   // Key store geometry.
   localparam int KEY_LEN = 1024;
   localparam int KEY_AW  = $clog2(KEY_LEN);

   // Fixed field widths of the channel beats.
   localparam int CMD_W      = 2;
   localparam int KEY_ADDR_W = 10;
   localparam int BYTE_W     = 8;

   // Configuration port geometry.
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int CSR_IDX_LO = 2;

   // Register indexes, taken from the word address.
   localparam logic REG_CHALLENGE  = 1'b0;
   localparam logic REG_ALLOW_HIGH = 1'b1;

   // Key sanitizing constants for decode mode.
   localparam logic [BYTE_W-1:0] HIGH_LIMIT = 8'd127;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;

   // Commands carried by an input beat.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_DATA  = 2'd2
   } cmd_type;

   // Result of the key mixing logic for one data byte.
   typedef struct packed {
      logic [BYTE_W-1:0] new_key;
      logic [KEY_AW-1:0] next_index;
   } mix_type;

endpackage

[design/rxps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxps_if
// Valid/ready channel interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface rxps_req_if;
   logic                                valid;
   logic                                ready;
   logic [rxps_pkg::CMD_W-1:0]          cmd;
   logic [rxps_pkg::KEY_ADDR_W-1:0]     key_addr;
   logic [rxps_pkg::BYTE_W-1:0]         byte_value;
   logic [rxps_pkg::BYTE_W-1:0]         seed_low;
   logic                                decode_mode;
   logic                                start_odd;

   modport source (
      output valid, cmd, key_addr, byte_value, seed_low, decode_mode, start_odd,
      input  ready
   );
   modport sink (
      input  valid, cmd, key_addr, byte_value, seed_low, decode_mode, start_odd,
      output ready
   );
endinterface

interface rxps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rxps_pkg::BYTE_W-1:0]   out_byte;

   modport source (output valid, out_byte, input ready);
   modport sink   (input valid, out_byte, output ready);
endinterface

[design/rolling_xor_packet_scrambler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_xor_packet_scrambler_top
// Packet byte scrambler with a rolling XOR key over a loaded key string.
// ----------------------------------------------------------------------------
// Path: a data beat is captured in the input stage register, waits there while the output
// register is full, and is then scrambled into the output register.
// Throughput: one beat of any kind per cycle unless a data beat waits for the output;
// the key store is read one index ahead, so a single registered RAM read port keeps pace.
// Reset: synchronous, active high; clears the running key, key index, parity,
// mode, configuration and the channel valids. The key store is not cleared.
// ----------------------------------------------------------------------------
module rolling_xor_packet_scrambler_top (
   input  logic                          clock,
   input  logic                          reset,
   rxps_req_if.sink                      req,
   rxps_rsp_if.source                    rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rxps_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rxps_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rxps_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   // Configuration registers.
   logic [rxps_pkg::BYTE_W-1:0] challenge_ff;
   logic                        allow_high_ff;
   logic                        csr_write;
   logic                        csr_idx;

   // Input stage.
   logic                            a_valid_ff, a_valid_in;
   rxps_pkg::cmd_type               a_cmd_ff;
   logic [rxps_pkg::KEY_ADDR_W-1:0] a_key_addr_ff;
   logic [rxps_pkg::BYTE_W-1:0]     a_byte_ff;
   logic [rxps_pkg::BYTE_W-1:0]     a_seed_ff;
   logic                            a_decode_ff;
   logic                            a_odd_ff;

   // Scrambler state.
   logic [rxps_pkg::BYTE_W-1:0] running_key_ff, running_key_in;
   logic [rxps_pkg::KEY_AW-1:0] key_index_ff, key_index_in;
   logic                        position_odd_ff, position_odd_in;
   logic                        in_decode_ff, in_decode_in;
   logic [rxps_pkg::BYTE_W-1:0] key0_ff;

   // Key store access and read bypass.
   logic                        wr_en;
   logic [rxps_pkg::KEY_AW-1:0] wr_addr;
   logic [rxps_pkg::KEY_AW-1:0] rd_addr;
   logic [rxps_pkg::BYTE_W-1:0] rd_data;
   logic                        byp_valid_ff, byp_valid_in;
   logic [rxps_pkg::BYTE_W-1:0] byp_data_ff;
   logic [rxps_pkg::BYTE_W-1:0] entry;

   // Output register.
   logic                        out_valid_ff, out_valid_in;
   logic [rxps_pkg::BYTE_W-1:0] out_byte_ff;

   logic                        out_free;
   logic                        a_fire;
   logic                        a_is_data;
   logic                        a_is_load;
   logic                        a_is_start;
   logic                        in_range;
   rxps_pkg::mix_type           mix;

   // ---------------------------------------------------------------------------
   // Configuration port.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[rxps_pkg::CSR_IDX_LO];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         challenge_ff  <= '0;
         allow_high_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_idx)
            rxps_pkg::REG_CHALLENGE:  challenge_ff  <= csr_pwdata[rxps_pkg::BYTE_W-1:0];
            rxps_pkg::REG_ALLOW_HIGH: allow_high_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rxps_pkg::REG_CHALLENGE:  csr_prdata = rxps_pkg::CSR_DW'(challenge_ff);
         rxps_pkg::REG_ALLOW_HIGH: csr_prdata = rxps_pkg::CSR_DW'(allow_high_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Handshake: the input stage moves on unless a data beat waits for the output.
   assign out_free   = (!out_valid_ff) || rsp.ready;
   assign a_is_data  = (a_cmd_ff == rxps_pkg::CMD_DATA);
   assign a_is_load  = (a_cmd_ff == rxps_pkg::CMD_LOAD);
   assign a_is_start = (a_cmd_ff == rxps_pkg::CMD_START);
   assign a_fire     = a_valid_ff && ((!a_is_data) || out_free);
   assign req.ready  = (!a_valid_ff) || a_fire;
   assign a_valid_in = req.valid || (a_valid_ff && !a_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Input beat capture.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         a_cmd_ff      <= rxps_pkg::cmd_type'(req.cmd);
         a_key_addr_ff <= req.key_addr;
         a_byte_ff     <= req.byte_value;
         a_seed_ff     <= req.seed_low;
         a_decode_ff   <= req.decode_mode;
         a_odd_ff      <= req.start_odd;
      end
   end

   // ---------------------------------------------------------------------------
   // Key store with one-ahead read; a load to the address being read is bypassed.
   assign in_range = (32'(a_key_addr_ff) < rxps_pkg::KEY_LEN);
   assign wr_en    = a_fire && a_is_load && in_range;
   assign wr_addr  = rxps_pkg::KEY_AW'(a_key_addr_ff);

   always_comb begin
      if (a_fire && a_is_data) begin
         rd_addr = mix.next_index;
      end else if (a_fire && a_is_start) begin
         rd_addr = '0;
      end else begin
         rd_addr = key_index_ff;
      end
      byp_valid_in = wr_en && (wr_addr == rd_addr);
   end

   rxps_ram #(
      .WIDTH (rxps_pkg::BYTE_W),
      .DEPTH (rxps_pkg::KEY_LEN)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (a_byte_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= byp_valid_in;
      end
   end

   // Bypass data and a copy of the first key byte for the NUL wrap.
   always_ff @(posedge clock) begin
      byp_data_ff <= a_byte_ff;
      if (wr_en && (wr_addr == '0)) begin
         key0_ff <= a_byte_ff;
      end
   end

   assign entry = byp_valid_ff ? byp_data_ff : rd_data;

   // ---------------------------------------------------------------------------
   // Key mixing for one data byte.
   rxps_mix u_mix (
      .entry        (entry),
      .key0         (key0_ff),
      .key_index    (key_index_ff),
      .running_key  (running_key_ff),
      .position_odd (position_odd_ff),
      .in_decode    (in_decode_ff),
      .allow_high   (allow_high_ff),
      .mix          (mix)
   );

   // State update for start and data beats.
   always_comb begin
      running_key_in  = running_key_ff;
      key_index_in    = key_index_ff;
      position_odd_in = position_odd_ff;
      in_decode_in    = in_decode_ff;
      if (a_fire) begin
         case (a_cmd_ff)
            rxps_pkg::CMD_START: begin
               running_key_in  = challenge_ff ^ a_seed_ff;
               key_index_in    = '0;
               position_odd_in = a_odd_ff;
               in_decode_in    = a_decode_ff;
            end
            rxps_pkg::CMD_DATA: begin
               running_key_in  = mix.new_key;
               key_index_in    = mix.next_index;
               position_odd_in = !position_odd_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_key_ff  <= '0;
         key_index_ff    <= '0;
         position_odd_ff <= 1'b0;
         in_decode_ff    <= 1'b0;
      end else begin
         running_key_ff  <= running_key_in;
         key_index_ff    <= key_index_in;
         position_odd_ff <= position_odd_in;
         in_decode_ff    <= in_decode_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register.
   assign out_valid_in = (a_fire && a_is_data) || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire && a_is_data) begin
         out_byte_ff <= a_byte_ff ^ mix.new_key;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;

endmodule

[design/rxps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rxps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read at the written address
   // returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rxps_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxps_mix
// Key byte selection, decode-mode sanitizing and running key update.
// ----------------------------------------------------------------------------
module rxps_mix (
   input  logic [rxps_pkg::BYTE_W-1:0] entry,
   input  logic [rxps_pkg::BYTE_W-1:0] key0,
   input  logic [rxps_pkg::KEY_AW-1:0] key_index,
   input  logic [rxps_pkg::BYTE_W-1:0] running_key,
   input  logic                        position_odd,
   input  logic                        in_decode,
   input  logic                        allow_high,
   output rxps_pkg::mix_type           mix
);

   logic [rxps_pkg::KEY_AW-1:0] used_index;
   logic [rxps_pkg::BYTE_W-1:0] key_byte;
   logic [rxps_pkg::BYTE_W-1:0] clean_byte;
   logic [rxps_pkg::BYTE_W-1:0] shifted_byte;

   always_comb begin
      // A NUL entry sends the walk back to the first key byte.
      if (entry == '0) begin
         used_index = '0;
         key_byte   = key0;
      end else begin
         used_index = key_index;
         key_byte   = entry;
      end

      // In decode mode, high bytes (unless allowed) and percent signs read as dots.
      if (in_decode && (((!allow_high) && (key_byte > rxps_pkg::HIGH_LIMIT))
                        || (key_byte == rxps_pkg::CH_PERCENT))) begin
         clean_byte = rxps_pkg::CH_DOT;
      end else begin
         clean_byte = key_byte;
      end

      // Odd positions mix in the key byte shifted left by one.
      if (position_odd) begin
         shifted_byte = {clean_byte[rxps_pkg::BYTE_W-2:0], 1'b0};
      end else begin
         shifted_byte = clean_byte;
      end

      mix.new_key = running_key ^ shifted_byte;

      // Step the index, wrapping after the last entry.
      if (used_index == rxps_pkg::KEY_AW'(rxps_pkg::KEY_LEN - 1)) begin
         mix.next_index = '0;
      end else begin
         mix.next_index = used_index + rxps_pkg::KEY_AW'(1);
      end
   end

endmodule

[design/rxps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxps_checker
// Port-level assertions for the scrambler top level, attached by bind.
// ----------------------------------------------------------------------------
module rxps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rxps_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [rxps_pkg::CSR_AW-1:0]   csr_paddr,
   input logic [rxps_pkg::CSR_DW-1:0]   csr_pwdata,
   input logic [rxps_pkg::CSR_DW-1:0]   csr_prdata
);

   // A stalled response beat stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte))
      else $error("response byte changed while stalled");

   // Reset leaves no response beat pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // With the output empty the block always takes a request beat.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output");

   // A challenge write reads back in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && (csr_paddr == '0)
      ##1 (csr_paddr == '0)
      |-> csr_prdata[rxps_pkg::BYTE_W-1:0] == $past(csr_pwdata[rxps_pkg::BYTE_W-1:0]))
      else $error("challenge register readback mismatch");

endmodule

bind rolling_xor_packet_scrambler_top rxps_checker u_rxps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .csr_psel     (csr_psel),
   .csr_penable  (csr_penable),
   .csr_pwrite   (csr_pwrite),
   .csr_paddr    (csr_paddr),
   .csr_pwdata   (csr_pwdata),
   .csr_prdata   (csr_prdata)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rolling XOR packet scrambler. Key strings, start
// beats and data bytes go in through the request channel; a built-in scrambler
// model predicts every output byte, and each response beat is compared with the
// oldest prediction. Both channels stall at random, and the configuration
// registers are swept between phases through the APB-style port.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [rxps_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES   = 4;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [rxps_pkg::CMD_W-1:0]      cmd;
      logic [rxps_pkg::KEY_ADDR_W-1:0] key_addr;
      logic [rxps_pkg::BYTE_W-1:0]     byte_value;
      logic [rxps_pkg::BYTE_W-1:0]     seed_low;
      logic                            decode_mode;
      logic                            start_odd;
   } scr_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [rxps_pkg::CSR_AW-1:0]   csr_paddr;
   logic [rxps_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [rxps_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   rxps_req_if req_bus ();
   rxps_rsp_if rsp_bus ();

   rolling_xor_packet_scrambler_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Scrambler model state and configuration mirror.
   logic [rxps_pkg::BYTE_W-1:0] key_mem [rxps_pkg::KEY_LEN];
   bit                          key_written [rxps_pkg::KEY_LEN];
   logic [rxps_pkg::BYTE_W-1:0] run_key;
   int unsigned                 key_idx;
   logic                        pos_odd;
   logic                        dec_on;
   logic [rxps_pkg::BYTE_W-1:0] cfg_challenge;
   logic                        cfg_allow;

   // Output bytes still owed by the block, oldest first.
   logic [rxps_pkg::BYTE_W-1:0] expected_out_bytes [$];

   int  error_count;
   int  n_checked;
   int  n_loads;
   int  n_starts;
   int  n_csr_writes;
   int  stall_cycles;
   bit  idle_on;
   bit  hold_req;
   bit  hold_done;

   // Clock generation.
   always #4 clock = ~clock;

   // Advance the model by one accepted beat and queue any output byte it owes.
   task automatic advance_scrambler(input scr_beat_type b);
      logic [rxps_pkg::BYTE_W-1:0] kb;
      case (b.cmd)
         rxps_pkg::CMD_LOAD: begin
            key_mem[b.key_addr] = b.byte_value;
            key_written[b.key_addr] = 1'b1;
            n_loads++;
         end
         rxps_pkg::CMD_START: begin
            run_key = cfg_challenge ^ b.seed_low;
            key_idx = 0;
            pos_odd = b.start_odd;
            dec_on  = b.decode_mode;
            n_starts++;
         end
         rxps_pkg::CMD_DATA: begin
            // A NUL entry sends the walk back to the head of the key string.
            if (key_mem[key_idx] == 8'h00) key_idx = 0;
            kb = key_mem[key_idx];
            // Decode mode replaces unsafe key characters with a dot.
            if (dec_on && ((!cfg_allow && kb > rxps_pkg::HIGH_LIMIT) ||
                           kb == rxps_pkg::CH_PERCENT)) kb = rxps_pkg::CH_DOT;
            run_key = run_key ^ (pos_odd ? {kb[rxps_pkg::BYTE_W-2:0], 1'b0} : kb);
            key_idx = (key_idx + 1 >= rxps_pkg::KEY_LEN) ? 0 : key_idx + 1;
            pos_odd = ~pos_odd;
            expected_out_bytes.push_back(b.byte_value ^ run_key);
         end
         default: ;
      endcase
   endtask

   // Random content in every field, then the command on top.
   function automatic scr_beat_type random_beat(input logic [rxps_pkg::CMD_W-1:0] cmd);
      scr_beat_type b;
      b = $bits(scr_beat_type)'($urandom);
      b.cmd = cmd;
      return b;
   endfunction

   // Key characters lean toward the ones that decode mode rewrites.
   function automatic logic [rxps_pkg::BYTE_W-1:0] pick_key_char();
      case ($urandom_range(0, 7))
         0:       return rxps_pkg::CH_PERCENT;
         1:       return rxps_pkg::HIGH_LIMIT;
         2:       return rxps_pkg::HIGH_LIMIT + 8'd1;
         3, 4:    return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(1, 126));
      endcase
   endfunction

   // Offer one beat and hold it until the block takes it.
   task automatic send_beat(input scr_beat_type b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= b.cmd;
      req_bus.key_addr    <= b.key_addr;
      req_bus.byte_value  <= b.byte_value;
      req_bus.seed_low    <= b.seed_low;
      req_bus.decode_mode <= b.decode_mode;
      req_bus.start_odd   <= b.start_odd;
      do @(posedge clock); while (!req_bus.ready);
      advance_scrambler(b);
   endtask

   task automatic send_load(input int addr, input logic [rxps_pkg::BYTE_W-1:0] value);
      scr_beat_type b;
      b = random_beat(rxps_pkg::CMD_LOAD);
      b.key_addr   = rxps_pkg::KEY_ADDR_W'(addr);
      b.byte_value = value;
      send_beat(b);
   endtask

   task automatic send_start(input logic [rxps_pkg::BYTE_W-1:0] seed, input logic dec,
                             input logic odd);
      scr_beat_type b;
      b = random_beat(rxps_pkg::CMD_START);
      b.seed_low    = seed;
      b.decode_mode = dec;
      b.start_odd   = odd;
      send_beat(b);
   endtask

   // Send a data byte, first filling any key entry the walk would read unwritten.
   task automatic send_data_byte(input logic [rxps_pkg::BYTE_W-1:0] data);
      scr_beat_type b;
      int unsigned  idx;
      idx = key_idx;
      if (key_written[idx] && key_mem[idx] == 8'h00) idx = 0;
      while (!key_written[idx]) begin
         send_load(int'(idx), ($urandom_range(0, 5) == 0) ? 8'h00 : pick_key_char());
         idx = key_idx;
         if (key_written[idx] && key_mem[idx] == 8'h00) idx = 0;
      end
      b = random_beat(rxps_pkg::CMD_DATA);
      b.byte_value = data;
      send_beat(b);
   endtask

   // Stop offering beats and let the block run empty.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (expected_out_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, then read it back through the same port.
   task automatic write_csr(input logic reg_idx, input logic [rxps_pkg::CSR_DW-1:0] value);
      logic [rxps_pkg::CSR_DW-1:0] mask;
      logic [rxps_pkg::CSR_DW-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rxps_pkg::CSR_AW'({reg_idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (reg_idx == rxps_pkg::REG_CHALLENGE) cfg_challenge = value[rxps_pkg::BYTE_W-1:0];
      else cfg_allow = value[0];
      n_csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      mask = (reg_idx == rxps_pkg::REG_CHALLENGE) ? 32'hFF : 32'h1;
      if ((readback & mask) !== (value & mask)) begin
         error_count++;
         $display("%0t: register %0d read back, expected %08h, actual %08h",
                  $time, reg_idx, value & mask, readback & mask);
      end
      @(posedge clock);
   endtask

   // Extreme bytes, sanitized key characters, NUL wrap, unused command and
   // data before any start beat.
   task automatic test_directed_cases();
      scr_beat_type b;
      write_csr(rxps_pkg::REG_CHALLENGE, 32'hFFFF_FFFF);
      write_csr(rxps_pkg::REG_ALLOW_HIGH, 32'h0);
      send_load(0, 8'hFF);
      send_load(1, rxps_pkg::CH_PERCENT);
      send_load(2, 8'h80);
      send_load(3, rxps_pkg::HIGH_LIMIT);
      send_load(4, 8'h00);
      send_load(rxps_pkg::KEY_LEN - 1, 8'hA5);
      // Data byte while the state is still as reset left it.
      send_data_byte(8'h00);
      send_start(8'h00, 1'b1, 1'b1);
      send_data_byte(8'hFF);
      send_data_byte(8'h00);
      send_data_byte(8'h5A);
      send_data_byte(8'hA5);
      send_data_byte(8'h3C);
      // The unused command must be dropped without a response.
      b = '1;
      b.cmd = CMD_UNUSED;
      send_beat(b);
      send_start(8'hFF, 1'b0, 1'b0);
      send_data_byte(8'h01);
      send_data_byte(8'h80);
      send_data_byte(8'hFE);
      wait_for_drain();
      // High key bytes survive decode once they are allowed.
      write_csr(rxps_pkg::REG_CHALLENGE, 32'h0);
      write_csr(rxps_pkg::REG_ALLOW_HIGH, 32'h1);
      send_start(8'hA5, 1'b1, 1'b0);
      repeat (4) send_data_byte(8'($urandom));
      wait_for_drain();
   endtask

   // Random messages with fresh key strings and some noise, over three settings.
   task automatic test_random_messages();
      int len;
      int pick;
      for (int s = 0; s < 3; s++) begin
         case (s)
            0: begin
               write_csr(rxps_pkg::REG_CHALLENGE, 32'h0);
               write_csr(rxps_pkg::REG_ALLOW_HIGH, 32'h0);
            end
            1: begin
               write_csr(rxps_pkg::REG_CHALLENGE, 32'hFF);
               write_csr(rxps_pkg::REG_ALLOW_HIGH, 32'h1);
            end
            default: begin
               write_csr(rxps_pkg::REG_CHALLENGE, $urandom);
               write_csr(rxps_pkg::REG_ALLOW_HIGH, $urandom);
            end
         endcase
         repeat (4) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               len = $urandom_range(1, 16);
               for (int i = 0; i < len; i++) send_load(i, pick_key_char());
               send_load(len, 8'h00);
            end
            // Noise: stray loads anywhere, unused commands, data with no restart.
            if (pick == 9) begin
               repeat (4) begin
                  case ($urandom_range(0, 2))
                     0:       send_load($urandom_range(0, rxps_pkg::KEY_LEN - 1),
                                        8'($urandom));
                     1:       send_beat(random_beat(CMD_UNUSED));
                     default: send_data_byte(8'($urandom));
                  endcase
               end
            end
            send_start(8'($urandom), 1'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 24)) send_data_byte(8'($urandom));
         end
         wait_for_drain();
      end
   endtask

   // A key with no NUL fills the whole store, so the walk runs off the end and
   // wraps. The response side holds off for a long stretch early on, and the
   // final stretch runs with no idling at all.
   task automatic test_long_key_walk();
      write_csr(rxps_pkg::REG_CHALLENGE, $urandom);
      write_csr(rxps_pkg::REG_ALLOW_HIGH, $urandom);
      for (int i = 0; i < rxps_pkg::KEY_LEN; i++) send_load(i, pick_key_char());
      send_start(8'($urandom), 1'($urandom), 1'($urandom));
      hold_req = 1'b1;
      for (int i = 0; i < rxps_pkg::KEY_LEN + 40; i++) begin
         if (i == rxps_pkg::KEY_LEN - 300) idle_on = 1'b0;
         send_data_byte(8'($urandom));
      end
   endtask

   // Response ready: random stall bursts, plus one long hold on request.
   initial begin : rsp_ready_driver
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each response beat with the oldest predicted byte.
   always @(posedge clock) begin : out_byte_check
      logic [rxps_pkg::BYTE_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_out_bytes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, expected none, actual %02h",
                     $time, rsp_bus.out_byte);
         end else begin
            want = expected_out_bytes.pop_front();
            n_checked++;
            if (rsp_bus.out_byte !== want) begin
               error_count++;
               if (error_count < 50)
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want, rsp_bus.out_byte);
            end
         end
      end
   end

   // Watchdog on cycles in which no channel makes progress.
   always @(posedge clock) begin : progress_watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Test sequence.
   initial begin : test_sequence
      clock               = 1'b0;
      reset               = 1'b1;
      idle_on             = 1'b1;
      hold_req            = 1'b0;
      hold_done           = 1'b0;
      error_count         = 0;
      n_checked           = 0;
      n_loads             = 0;
      n_starts            = 0;
      n_csr_writes        = 0;
      stall_cycles        = 0;
      run_key             = '0;
      key_idx             = 0;
      pos_odd             = 1'b0;
      dec_on              = 1'b0;
      cfg_challenge       = '0;
      cfg_allow           = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = rxps_pkg::CMD_LOAD;
      req_bus.key_addr    = '0;
      req_bus.byte_value  = '0;
      req_bus.seed_low    = '0;
      req_bus.decode_mode = 1'b0;
      req_bus.start_odd   = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      for (int i = 0; i < rxps_pkg::KEY_LEN; i++) begin
         key_mem[i]     = '0;
         key_written[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_messages();
      test_long_key_walk();
      wait_for_drain();

      $display("Checked %0d scrambled bytes over %0d key loads and %0d message starts,",
               n_checked, n_loads, n_starts);
      $display("with %0d register writes, a full-store key wrap and a long response hold.",
               n_csr_writes);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
